>>> hw/rtl/mlfq_pkg.sv
package mlfq_pkg;

	localparam int MAX_JOBS = 16;
	localparam int ID_W = $clog2(MAX_JOBS);
	localparam int CNT_W = ID_W + 1;
	localparam logic [16:0] WAIT_MAX = 17'h1FFFF;

	// command codes
	localparam logic CMD_ADMIT = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// status codes
	localparam logic [1:0] ST_TICK = 2'd0;
	localparam logic [1:0] ST_ADMIT = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	// served level codes
	localparam logic [1:0] LV_IDLE = 2'd0;
	localparam logic [1:0] LV_RR = 2'd1;
	localparam logic [1:0] LV_FC = 2'd2;

	// run event codes
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_DEMOTE = 2'd1;
	localparam logic [1:0] EV_IO = 2'd2;
	localparam logic [1:0] EV_FINISH = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_QUANTUM = 2'd0;
	localparam logic [1:0] REG_AGING = 2'd1;
	localparam logic [1:0] REG_IO = 2'd2;

	typedef struct packed {
		logic        command;
		logic [15:0] burst_length;
		logic [7:0]  io_count;
		logic        start_level;
	} mlfq_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  assigned_id;
		logic [31:0] time_now;
		logic [1:0]  served_level;
		logic [3:0]  running_id;
		logic        new_segment;
		logic [1:0]  run_event;
		logic [4:0]  promoted_count;
		logic        io_done;
		logic [3:0]  io_done_id;
		logic        all_idle;
	} mlfq_out_t;

	typedef struct packed {
		logic [1:0]  idx;
		logic [15:0] data;
	} mlfq_cfg_t;

	// controller to datapath
	typedef struct packed {
		logic admit;    // run admit step
		logic run;      // run the job at the front
		logic age_step; // age/promote one fc entry
		logic io_step;  // service I/O front
		logic finish;   // latch result
	} mlfq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic age_done;
	} mlfq_sts_t;

endpackage

>>> hw/rtl/mlfq_if.sv
interface mlfq_in_if;
	import mlfq_pkg::*;
	logic     valid;
	logic     ready;
	mlfq_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mlfq_out_if;
	import mlfq_pkg::*;
	logic      valid;
	logic      ready;
	mlfq_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mlfq_cfg_if;
	import mlfq_pkg::*;
	logic      valid;
	logic      ready;
	mlfq_cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/mlfq_ctrl.sv
module mlfq_ctrl
	import mlfq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_command,
	output logic      in_ready,
	input  logic      out_busy,
	input  mlfq_sts_t sts,
	output mlfq_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_AGE = 3'd1;
	localparam logic [2:0] S_IO = 3'd2;
	localparam logic [2:0] S_DONE = 3'd3;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// sequence one item through its steps
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					if (in_command == CMD_ADMIT) begin
						cmd.admit = 1'b1;
						state_d = S_DONE;
					end else begin
						cmd.run = 1'b1;
						state_d = S_AGE;
					end
				end
			end
			S_AGE: begin
				if (sts.age_done) state_d = S_IO;
				else cmd.age_step = 1'b1;
			end
			S_IO: begin
				cmd.io_step = 1'b1;
				state_d = S_DONE;
			end
			// hold until the output register has room
			S_DONE: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

`ifndef SYNTHESIS
	a_finish_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !cmd.finish) else $error("finish repeated");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> state_q == S_IDLE) else $error("accept busy");
	a_io_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.io_step |=> state_q == S_DONE) else $error("io not followed by finish");
`endif

endmodule

>>> hw/rtl/mlfq_dp.sv
module mlfq_dp
	import mlfq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  mlfq_cmd_t cmd,
	output mlfq_sts_t sts,
	input  mlfq_in_t  item,
	input  logic      cfg_we,
	input  mlfq_cfg_t cfg,
	output mlfq_out_t res,
	output logic      res_load
);

	logic [7:0]  quantum_q;
	logic [15:0] aging_q, iodur_q;
	logic [ID_W-1:0] rr_q [MAX_JOBS];
	logic [ID_W-1:0] fc_q [MAX_JOBS];
	logic [ID_W-1:0] io_q [MAX_JOBS];
	logic [15:0] btot_q [MAX_JOBS];
	logic [15:0] bdone_q [MAX_JOBS];
	logic [7:0]  iol_q [MAX_JOBS];
	logic [16:0] wait_q [MAX_JOBS];
	logic [ID_W-1:0] rr_head_q, io_head_q;
	logic [CNT_W-1:0] rr_cnt_q, fc_cnt_q, io_len_q, next_id_q, pos_q;
	logic [ID_W:0] chart_q;
	logic [31:0] tick_q;
	logic io_empty_q, fresh_v_q;
	logic [ID_W-1:0] fresh_q;
	mlfq_out_t r_q;

	// helpers for the current run
	logic [ID_W-1:0] rid, aid, iid;
	logic [15:0] bd1;
	logic [16:0] w1, aw, iw;
	logic [ID_W-1:0] rr_tail, io_tail;
	logic [ID_W:0] chart_new;
	logic age_here;

	assign rr_tail = rr_head_q + rr_cnt_q[ID_W-1:0];
	assign io_tail = io_head_q + io_len_q[ID_W-1:0];
	assign rid = (rr_cnt_q != '0) ? rr_q[rr_head_q] : fc_q[0];
	assign bd1 = bdone_q[rid] + 16'd1;
	assign w1 = (wait_q[rid] < WAIT_MAX) ? wait_q[rid] + 17'd1 : wait_q[rid];
	assign chart_new = ((rr_cnt_q == '0) && (fc_cnt_q == '0)) ?
		(ID_W+1)'(MAX_JOBS) : {1'b0, rid};
	assign aid = fc_q[pos_q[ID_W-1:0]];
	assign age_here = !(fresh_v_q && aid == fresh_q) && wait_q[aid] < WAIT_MAX;
	assign aw = age_here ? wait_q[aid] + 17'd1 : wait_q[aid];
	assign iid = io_q[io_head_q];
	assign iw = (wait_q[iid] < WAIT_MAX) ? wait_q[iid] + 17'd1 : wait_q[iid];
	assign sts.age_done = (pos_q >= fc_cnt_q);
	assign res_load = cmd.finish;

	// present the result with the live idle flag
	always_comb begin
		res = r_q;
		res.all_idle = (rr_cnt_q == '0) && (fc_cnt_q == '0) && (io_len_q == '0);
	end

	// control state of the scheduler
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= 8'd10;
			aging_q <= 16'd100;
			iodur_q <= 16'd20;
			rr_head_q <= '0;
			io_head_q <= '0;
			rr_cnt_q <= '0;
			fc_cnt_q <= '0;
			io_len_q <= '0;
			next_id_q <= '0;
			chart_q <= (ID_W+1)'(MAX_JOBS + 1);
			tick_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg.idx)
					REG_QUANTUM: quantum_q <= cfg.data[7:0];
					REG_AGING: aging_q <= cfg.data;
					REG_IO: iodur_q <= cfg.data;
					default: ;
				endcase
			end
			if (cmd.admit && next_id_q < CNT_W'(MAX_JOBS)) begin
				next_id_q <= next_id_q + 1'b1;
				if (item.start_level) fc_cnt_q <= fc_cnt_q + 1'b1;
				else rr_cnt_q <= rr_cnt_q + 1'b1;
			end
			if (cmd.run) begin
				tick_q <= tick_q + 32'd1;
				chart_q <= chart_new;
				if (rr_cnt_q != '0) begin
					if (bd1 >= btot_q[rid]) begin
						rr_head_q <= rr_head_q + 1'b1;
						rr_cnt_q <= rr_cnt_q - 1'b1;
						if (iol_q[rid] != '0) io_len_q <= io_len_q + 1'b1;
					end else if (w1 >= {9'd0, quantum_q}) begin
						rr_head_q <= rr_head_q + 1'b1;
						rr_cnt_q <= rr_cnt_q - 1'b1;
						fc_cnt_q <= fc_cnt_q + 1'b1;
					end
				end else if (fc_cnt_q != '0 && bd1 >= btot_q[rid]) begin
					fc_cnt_q <= fc_cnt_q - 1'b1;
					if (iol_q[rid] != '0) io_len_q <= io_len_q + 1'b1;
				end
			end
			if (cmd.age_step && aw >= {1'b0, aging_q}) begin
				fc_cnt_q <= fc_cnt_q - 1'b1;
				rr_cnt_q <= rr_cnt_q + 1'b1;
			end
			if (cmd.io_step && io_len_q != '0 && !io_empty_q && iw >= {1'b0, iodur_q}) begin
				io_head_q <= io_head_q + 1'b1;
				io_len_q <= io_len_q - 1'b1;
				rr_cnt_q <= rr_cnt_q + 1'b1;
			end
		end
	end

	// payload tables and result
	always_ff @(posedge clk) begin
		if (cmd.admit) begin
			r_q.time_now <= '0;
			r_q.served_level <= LV_IDLE;
			r_q.running_id <= '0;
			r_q.new_segment <= 1'b0;
			r_q.run_event <= EV_NONE;
			r_q.promoted_count <= '0;
			r_q.io_done <= 1'b0;
			r_q.io_done_id <= '0;
			if (next_id_q < CNT_W'(MAX_JOBS)) begin
				btot_q[next_id_q[ID_W-1:0]] <= item.burst_length;
				bdone_q[next_id_q[ID_W-1:0]] <= '0;
				iol_q[next_id_q[ID_W-1:0]] <= item.io_count;
				wait_q[next_id_q[ID_W-1:0]] <= '0;
				if (item.start_level) fc_q[fc_cnt_q[ID_W-1:0]] <= next_id_q[ID_W-1:0];
				else rr_q[rr_tail] <= next_id_q[ID_W-1:0];
				r_q.status <= ST_ADMIT;
				r_q.assigned_id <= 4'(next_id_q[ID_W-1:0]);
			end else begin
				r_q.status <= ST_REJECT;
				r_q.assigned_id <= '0;
			end
		end
		if (cmd.run) begin
			r_q.status <= ST_TICK;
			r_q.assigned_id <= '0;
			r_q.time_now <= tick_q;
			r_q.new_segment <= (chart_new != chart_q);
			r_q.promoted_count <= '0;
			r_q.io_done <= 1'b0;
			r_q.io_done_id <= '0;
			io_empty_q <= (io_len_q == '0);
			pos_q <= '0;
			if (rr_cnt_q != '0 || fc_cnt_q != '0) begin
				r_q.served_level <= (rr_cnt_q != '0) ? LV_RR : LV_FC;
				r_q.running_id <= 4'(rid);
				bdone_q[rid] <= bd1;
				if (bd1 >= btot_q[rid]) begin
					fresh_v_q <= 1'b0;
					if (iol_q[rid] != '0) begin
						iol_q[rid] <= iol_q[rid] - 8'd1;
						wait_q[rid] <= '0;
						io_q[io_tail] <= rid;
						r_q.run_event <= EV_IO;
					end else begin
						if (rr_cnt_q != '0) wait_q[rid] <= w1;
						r_q.run_event <= EV_FINISH;
					end
					if (rr_cnt_q == '0) begin
						for (int i = 0; i < MAX_JOBS - 1; i++) fc_q[i] <= fc_q[i+1];
					end
				end else if (rr_cnt_q != '0) begin
					if (w1 >= {9'd0, quantum_q}) begin
						wait_q[rid] <= '0;
						fc_q[fc_cnt_q[ID_W-1:0]] <= rid;
						fresh_v_q <= 1'b1;
						fresh_q <= rid;
						r_q.run_event <= EV_DEMOTE;
					end else begin
						wait_q[rid] <= w1;
						fresh_v_q <= 1'b0;
						r_q.run_event <= EV_NONE;
					end
				end else begin
					wait_q[rid] <= '0;
					fresh_v_q <= 1'b1;
					fresh_q <= rid;
					r_q.run_event <= EV_NONE;
				end
			end else begin
				r_q.served_level <= LV_IDLE;
				r_q.running_id <= '0;
				r_q.run_event <= EV_NONE;
				fresh_v_q <= 1'b0;
			end
		end
		// one fc entry per cycle: age, then promote or advance
		if (cmd.age_step) begin
			if (aw >= {1'b0, aging_q}) begin
				wait_q[aid] <= '0;
				rr_q[rr_tail] <= aid;
				for (int i = 0; i < MAX_JOBS - 1; i++)
					if (CNT_W'(i) >= pos_q) fc_q[i] <= fc_q[i+1];
				r_q.promoted_count <= r_q.promoted_count + 5'd1;
			end else begin
				wait_q[aid] <= aw;
				pos_q <= pos_q + 1'b1;
			end
		end
		if (cmd.io_step && io_len_q != '0 && !io_empty_q) begin
			if (iw >= {1'b0, iodur_q}) begin
				bdone_q[iid] <= '0;
				wait_q[iid] <= '0;
				rr_q[rr_tail] <= iid;
				r_q.io_done <= 1'b1;
				r_q.io_done_id <= 4'(iid);
			end else begin
				wait_q[iid] <= iw;
			end
		end
		if (cmd.finish)
			r_q.all_idle <= (rr_cnt_q == '0) && (fc_cnt_q == '0) && (io_len_q == '0);
	end

`ifndef SYNTHESIS
	a_rr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rr_cnt_q <= CNT_W'(MAX_JOBS)) else $error("rr overflow");
	a_ids_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q <= CNT_W'(MAX_JOBS)) else $error("id overflow");
	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run |=> tick_q == $past(tick_q) + 32'd1) else $error("tick miss");
`endif

endmodule

>>> hw/rtl/multilevel_feedback_queue_scheduler.sv
// Two-level feedback scheduler. Each input beat is an admit or a tick and
// gives one result beat. A tick runs the front job, then ages the
// first-come entries still waiting after the run step, one entry per
// cycle, and then services the I/O front.
// One item is in work at a time. A finished result is held in an output
// register, so the next item is accepted while it waits; that item stalls
// at its last step while the register is still full.
module multilevel_feedback_queue_scheduler
	import mlfq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	mlfq_in_if.sink in_ch,
	mlfq_out_if.source out_ch,
	mlfq_cfg_if.sink cfg_ch
);

	mlfq_cmd_t cmd;
	mlfq_sts_t sts;
	mlfq_out_t res, out_q;
	logic res_load, out_v_q, out_busy;

	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;
	assign out_busy = out_v_q && !out_ch.ready;

	mlfq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_command(in_ch.data.command),
		.in_ready(in_ch.ready), .out_busy(out_busy),
		.sts(sts), .cmd(cmd)
	);

	mlfq_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.item(in_ch.data), .cfg_we(cfg_ch.valid), .cfg(cfg_ch.data),
		.res(res), .res_load(res_load)
	);

	// hold result until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (res_load) out_v_q <= 1'b1;
		else if (out_ch.ready) out_v_q <= 1'b0;
	end

	// capture the finished result
	always_ff @(posedge clk) begin
		if (res_load) out_q <= res;
	end

`ifndef SYNTHESIS
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!out_v_q || out_ch.ready)) else $error("result overwritten");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ch.ready) |=> out_v_q) else $error("result dropped");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ch.ready) |=> $stable(out_q)) else $error("result changed");
`endif

endmodule

>>> bench/multilevel_feedback_queue_scheduler_tb.sv
module multilevel_feedback_queue_scheduler_tb;
	import mlfq_pkg::*;

	localparam int unsigned CHART_IDLE = MAX_JOBS;
	localparam int unsigned CHART_NONE = MAX_JOBS + 1;
	localparam int RANDOM_ITEMS = 190;

	typedef struct {
		mlfq_in_t  item;
		bit        typed;
		mlfq_out_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	mlfq_in_if  in_ch();
	mlfq_out_if out_ch();
	mlfq_cfg_if cfg_ch();

	multilevel_feedback_queue_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	// scheduler shadow state
	int unsigned rr_ring[MAX_JOBS], rr_front, rr_len;
	int unsigned fc_ids[MAX_JOBS], fc_len;
	int unsigned io_ring[MAX_JOBS], io_front, io_waiting;
	int unsigned burst_total[MAX_JOBS], burst_done[MAX_JOBS];
	int unsigned io_left[MAX_JOBS], wait_ticks[MAX_JOBS];
	int unsigned last_chart, id_counter;
	bit [31:0] tick_count;
	int unsigned quantum, aging_lim, io_ticks;

	mlfq_out_t pending_results[$];
	int failures = 0;
	int in_idle_pct = 0;
	int out_idle_pct = 0;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function void rr_add(int unsigned id);
		if (rr_len < MAX_JOBS) begin
			rr_ring[(rr_front + rr_len) % MAX_JOBS] = id;
			rr_len++;
		end
	endfunction

	function void fc_add(int unsigned id);
		if (fc_len < MAX_JOBS) begin
			fc_ids[fc_len] = id;
			fc_len++;
		end
	endfunction

	function void fc_drop(int unsigned pos);
		for (int unsigned k = pos; k + 1 < fc_len; k++)
			fc_ids[k] = fc_ids[k + 1];
		fc_len--;
	endfunction

	function void bump_wait(int unsigned id);
		if (wait_ticks[id] < WAIT_MAX)
			wait_ticks[id]++;
	endfunction

	// burst complete: enter I/O while operations remain, else finish
	function logic [1:0] close_burst(int unsigned id);
		if (io_left[id] > 0) begin
			io_left[id]--;
			wait_ticks[id] = 0;
			if (io_waiting < MAX_JOBS) begin
				io_ring[(io_front + io_waiting) % MAX_JOBS] = id;
				io_waiting++;
			end
			return EV_IO;
		end
		return EV_FINISH;
	endfunction

	// advance the shadow scheduler by one item and return its result
	function mlfq_out_t schedule_step(mlfq_in_t it);
		mlfq_out_t r;
		int unsigned id, fresh, chart, k;
		bit io_was_empty;
		r = '0;
		if (it.command == CMD_ADMIT) begin
			if (id_counter >= MAX_JOBS) begin
				r.status = ST_REJECT;
			end else begin
				id = id_counter;
				id_counter++;
				burst_total[id] = 32'(it.burst_length);
				burst_done[id] = 0;
				io_left[id] = 32'(it.io_count);
				wait_ticks[id] = 0;
				if (it.start_level)
					fc_add(id);
				else
					rr_add(id);
				r.status = ST_ADMIT;
				r.assigned_id = 4'(id);
			end
		end else begin
			r.status = ST_TICK;
			io_was_empty = (io_waiting == 0);
			fresh = CHART_NONE;
			r.time_now = tick_count;
			tick_count++;

			// run one front job
			if (rr_len > 0) begin
				id = rr_ring[rr_front];
				r.served_level = LV_RR;
				r.running_id = 4'(id);
				burst_done[id] = (burst_done[id] + 1) & 16'hFFFF;
				bump_wait(id);
				if (burst_done[id] >= burst_total[id]) begin
					rr_front = (rr_front + 1) % MAX_JOBS;
					rr_len--;
					r.run_event = close_burst(id);
				end else if (wait_ticks[id] >= quantum) begin
					rr_front = (rr_front + 1) % MAX_JOBS;
					rr_len--;
					wait_ticks[id] = 0;
					fc_add(id);
					fresh = id;
					r.run_event = EV_DEMOTE;
				end
			end else if (fc_len > 0) begin
				id = fc_ids[0];
				r.served_level = LV_FC;
				r.running_id = 4'(id);
				burst_done[id] = (burst_done[id] + 1) & 16'hFFFF;
				if (burst_done[id] >= burst_total[id]) begin
					fc_drop(0);
					r.run_event = close_burst(id);
				end else begin
					wait_ticks[id] = 0;
					fresh = id;
				end
			end

			chart = (r.served_level == LV_IDLE) ? CHART_IDLE : r.running_id;
			if (chart != last_chart) begin
				r.new_segment = 1'b1;
				last_chart = chart;
			end

			// age waiting first-come jobs, then promote in list order
			for (k = 0; k < fc_len; k++)
				if (fc_ids[k] != fresh)
					bump_wait(fc_ids[k]);
			k = 0;
			while (k < fc_len) begin
				id = fc_ids[k];
				if (wait_ticks[id] >= aging_lim) begin
					wait_ticks[id] = 0;
					rr_add(id);
					fc_drop(k);
					r.promoted_count++;
				end else begin
					k++;
				end
			end

			// service the I/O front unless it just entered
			if (io_waiting > 0 && !io_was_empty) begin
				id = io_ring[io_front];
				bump_wait(id);
				if (wait_ticks[id] >= io_ticks) begin
					burst_done[id] = 0;
					wait_ticks[id] = 0;
					io_front = (io_front + 1) % MAX_JOBS;
					io_waiting--;
					rr_add(id);
					r.io_done = 1'b1;
					r.io_done_id = 4'(id);
				end
			end
		end
		r.all_idle = (rr_len == 0 && fc_len == 0 && io_waiting == 0);
		return r;
	endfunction

	// drive one item, hold it until accepted
	task send_item(input mlfq_in_t it, input bit typed, input mlfq_out_t want);
		mlfq_out_t predicted;
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		predicted = schedule_step(it);
		pending_results.insert(pending_results.size(), typed ? want : predicted);
		@(negedge clk);
	endtask

	task write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{idx: idx, data: value};
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_QUANTUM: quantum = 32'(value[7:0]);
			REG_AGING: aging_lim = 32'(value);
			REG_IO: io_ticks = 32'(value);
			default: ;
		endcase
		@(negedge clk);
	endtask

	// wait until the block is idle, then load all three registers
	task load_settings(input logic [7:0] q, input logic [15:0] a, input logic [15:0] io);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
		write_reg(REG_QUANTUM, {8'd0, q});
		write_reg(REG_AGING, a);
		write_reg(REG_IO, io);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	function mlfq_in_t random_item();
		mlfq_in_t it;
		it.command = ($urandom_range(0, 99) < 12) ? CMD_ADMIT : CMD_TICK;
		// short bursts keep live jobs moving; rejected admits take any value
		if (id_counter < MAX_JOBS && $urandom_range(0, 9) != 0)
			it.burst_length = 16'($urandom_range(1, 6));
		else
			it.burst_length = 16'($urandom_range(1, 65535));
		if ($urandom_range(0, 9) != 0)
			it.io_count = 8'($urandom_range(0, 3));
		else
			it.io_count = 8'($urandom_range(0, 255));
		it.start_level = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task check_field(input string name, input longint unsigned want, input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	// result receiver
	always @(negedge clk)
		out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);

	// compare each result beat against the oldest expectation
	always @(posedge clk) begin
		mlfq_out_t want, got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (pending_results.size() == 0) begin
				$error("unexpected result beat, status %0d", got.status);
				failures++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, got.status);
				check_field("assigned_id", want.assigned_id, got.assigned_id);
				check_field("time_now", want.time_now, got.time_now);
				check_field("served_level", want.served_level, got.served_level);
				check_field("running_id", want.running_id, got.running_id);
				check_field("new_segment", want.new_segment, got.new_segment);
				check_field("run_event", want.run_event, got.run_event);
				check_field("promoted_count", want.promoted_count, got.promoted_count);
				check_field("io_done", want.io_done, got.io_done);
				check_field("io_done_id", want.io_done_id, got.io_done_id);
				check_field("all_idle", want.all_idle, got.all_idle);
			end
		end
	end

	// run limit
	initial begin
		#20_000_000;
		$display("multilevel_feedback_queue_scheduler verification failed");
		$finish;
	end

	stim_row_t directed_rows[21];

	initial begin
		// known values, hold reset
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		quantum = 10;
		aging_lim = 100;
		io_ticks = 20;
		rr_front = 0; rr_len = 0; fc_len = 0; io_front = 0; io_waiting = 0;
		last_chart = CHART_NONE;
		tick_count = '0;
		id_counter = 0;

		// idle ticks, a one-tick job, the widest fields, a burst and a demotion
		directed_rows[0] = '{'{CMD_TICK, 16'd0, 8'd0, 1'b0}, 1'b1,
			'{ST_TICK, 4'd0, 32'd0, LV_IDLE, 4'd0, 1'b1, EV_NONE, 5'd0, 1'b0, 4'd0, 1'b1}};
		directed_rows[1] = '{'{CMD_TICK, 16'hFFFF, 8'hFF, 1'b1}, 1'b1,
			'{ST_TICK, 4'd0, 32'd1, LV_IDLE, 4'd0, 1'b0, EV_NONE, 5'd0, 1'b0, 4'd0, 1'b1}};
		directed_rows[2] = '{'{CMD_ADMIT, 16'd1, 8'd0, 1'b0}, 1'b1,
			'{ST_ADMIT, 4'd0, 32'd0, LV_IDLE, 4'd0, 1'b0, EV_NONE, 5'd0, 1'b0, 4'd0, 1'b0}};
		directed_rows[3] = '{'{CMD_TICK, 16'd0, 8'd0, 1'b0}, 1'b1,
			'{ST_TICK, 4'd0, 32'd2, LV_RR, 4'd0, 1'b1, EV_FINISH, 5'd0, 1'b0, 4'd0, 1'b1}};
		directed_rows[4] = '{'{CMD_ADMIT, 16'hFFFF, 8'hFF, 1'b1}, 1'b1,
			'{ST_ADMIT, 4'd1, 32'd0, LV_IDLE, 4'd0, 1'b0, EV_NONE, 5'd0, 1'b0, 4'd0, 1'b0}};
		directed_rows[5] = '{'{CMD_ADMIT, 16'd2, 8'd1, 1'b0}, 1'b0, '0};
		directed_rows[6] = '{'{CMD_ADMIT, 16'd12, 8'd0, 1'b0}, 1'b0, '0};
		for (int k = 7; k < 21; k++)
			directed_rows[k] = '{'{CMD_TICK, 16'd0, 8'd0, 1'b0}, 1'b0, '0};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[k])
			send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);

		// random phases: lowest limits, two midrange sets, then highest limits
		load_settings(8'd1, 16'd1, 16'd1);
		in_idle_pct = 12;
		out_idle_pct = 49;
		repeat (RANDOM_ITEMS) send_item(random_item(), 1'b0, '0);

		load_settings(8'd3, 16'd7, 16'd5);
		in_idle_pct = 49;
		out_idle_pct = 12;
		repeat (RANDOM_ITEMS) send_item(random_item(), 1'b0, '0);

		load_settings(8'd2, 16'd4, 16'd3);
		in_idle_pct = 0;
		out_idle_pct = 0;
		repeat (RANDOM_ITEMS) send_item(random_item(), 1'b0, '0);

		load_settings(8'd255, 16'd65535, 16'd65535);
		repeat (RANDOM_ITEMS) send_item(random_item(), 1'b0, '0);

		// drain, then allow stray beats to show up
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (failures == 0)
			$display("multilevel_feedback_queue_scheduler verification clean");
		else
			$display("multilevel_feedback_queue_scheduler verification failed");
		$finish;
	end

endmodule
